// ===== rtl/tlbpt_pkg.sv =====
// Shared types and constants for the TLB page-table translator.
// No dependencies; used by every module of the block by scoped names.
package tlbpt_pkg;

    localparam int VA_W        = 16;
    localparam int CNT_W       = 32;
    localparam int IN_TDATA_W  = 16;
    // physical address, outcome, three counts = 114 bits, padded to bytes
    localparam int OUT_FIELD_W = VA_W + 2 + 3 * CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int DEF_TLB_DEPTH  = 16;
    localparam int DEF_PAGE_COUNT = 256;
    localparam int DEF_PAGE_BYTES = 256;

    typedef enum logic [1:0] {
        OUT_TLB_HIT  = 2'd0,
        OUT_PAGE_HIT = 2'd1,
        OUT_FAULT    = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;   // clear one present-map entry
        logic load;     // capture incoming address word
        logic rd_en;    // tag compare and present-map read
        logic commit;   // update state, load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last; // clearing pass at its last entry
        logic out_free; // output register can take a word this cycle
    } t_stat;

endpackage

// ===== rtl/tlbpt_ctrl.sv =====
// Controller FSM of the translator: clearing pass, accept, lookup, update.
// Depends on tlbpt_pkg (state enum, command and status structs).
module tlbpt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output tlbpt_pkg::t_cmd  o_cmd,
    input  tlbpt_pkg::t_stat i_stat
);

    tlbpt_pkg::t_state r_state;
    tlbpt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlbpt_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            tlbpt_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = tlbpt_pkg::S_IDLE;
                end
            end
            tlbpt_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tlbpt_pkg::S_LOOKUP;
                end
            end
            tlbpt_pkg::S_LOOKUP: begin
                o_cmd.rd_en = 1'b1;
                n_state     = tlbpt_pkg::S_UPDATE;
            end
            tlbpt_pkg::S_UPDATE: begin
                // wait here while the previous word is still held
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = tlbpt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlbpt_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/tlbpt_dp.sv =====
// Datapath: TLB tag lanes, FIFO insert pointer, present-map memory,
// saturating counters and output register. Depends on tlbpt_pkg.
module tlbpt_dp #(
    parameter int TLB_DEPTH  = tlbpt_pkg::DEF_TLB_DEPTH,
    parameter int PAGE_COUNT = tlbpt_pkg::DEF_PAGE_COUNT,
    parameter int PAGE_BYTES = tlbpt_pkg::DEF_PAGE_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tlbpt_pkg::t_cmd                     i_cmd,
    output tlbpt_pkg::t_stat                    o_stat,
    input  logic [tlbpt_pkg::IN_TDATA_W-1:0]    i_va,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [tlbpt_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);

    // PAGE_COUNT and PAGE_BYTES are powers of two
    localparam int PG_W   = $clog2(PAGE_COUNT);
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int SLOT_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int CNT_W  = tlbpt_pkg::CNT_W;
    localparam int VA_W   = tlbpt_pkg::VA_W;

    logic [31:0]           w_va_ext;
    logic [PG_W-1:0]       r_page;
    logic [OFF_W-1:0]      r_off;
    logic [PG_W-1:0]       r_tag [TLB_DEPTH];
    logic [TLB_DEPTH-1:0]  r_tlb_vld;
    logic [TLB_DEPTH-1:0]  w_match;
    logic                  r_hit;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_present [PAGE_COUNT];
    logic                  r_pres_rd;
    logic [PG_W-1:0]       r_clr_addr;
    logic                  w_pres_we;
    logic [PG_W-1:0]       w_pres_wa;
    logic                  w_pres_wd;
    logic [CNT_W-1:0]      r_tlb_cnt;
    logic [CNT_W-1:0]      r_pg_cnt;
    logic [CNT_W-1:0]      r_flt_cnt;
    logic [CNT_W-1:0]      n_tlb_cnt;
    logic [CNT_W-1:0]      n_pg_cnt;
    logic [CNT_W-1:0]      n_flt_cnt;
    tlbpt_pkg::t_outcome   w_outcome;
    logic [VA_W-1:0]       w_phys;
    logic                  r_out_valid;
    logic [tlbpt_pkg::OUT_TDATA_W-1:0] r_out_data;

    assign w_va_ext = 32'(i_va);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= PG_W'(w_va_ext >> OFF_W);
            r_off  <= OFF_W'(i_va);
        end
    end

    // one comparator per TLB lane
    always_comb begin
        for (int i = 0; i < TLB_DEPTH; i++) begin
            w_match[i] = r_tlb_vld[i] && (r_tag[i] == r_page);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_hit <= |w_match;
        end
    end

    // FIFO replacement: r_slot points at the next slot to fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_vld <= '0;
            r_slot    <= '0;
        end else if (i_cmd.commit && !r_hit) begin
            r_tlb_vld[r_slot] <= 1'b1;
            r_slot <= (r_slot == SLOT_W'(TLB_DEPTH - 1)) ? '0 : r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_hit) begin
            r_tag[r_slot] <= r_page;
        end
    end

    // present map: one write port shared by clearing pass and fault marking
    assign w_pres_we = i_cmd.clr_wr || (i_cmd.commit && !r_hit && !r_pres_rd);
    assign w_pres_wa = i_cmd.clr_wr ? r_clr_addr : r_page;
    assign w_pres_wd = !i_cmd.clr_wr;

    always_ff @(posedge i_clk) begin
        if (w_pres_we) begin
            r_present[w_pres_wa] <= w_pres_wd;
        end
        if (i_cmd.rd_en) begin
            r_pres_rd <= r_present[r_page];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_stat.clr_last = (r_clr_addr == PG_W'(PAGE_COUNT - 1));
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_tlb_cnt = r_tlb_cnt;
        n_pg_cnt  = r_pg_cnt;
        n_flt_cnt = r_flt_cnt;
        if (r_hit) begin
            w_outcome = tlbpt_pkg::OUT_TLB_HIT;
            if (r_tlb_cnt != '1) n_tlb_cnt = r_tlb_cnt + 1'b1;
        end else if (r_pres_rd) begin
            w_outcome = tlbpt_pkg::OUT_PAGE_HIT;
            if (r_pg_cnt != '1) n_pg_cnt = r_pg_cnt + 1'b1;
        end else begin
            w_outcome = tlbpt_pkg::OUT_FAULT;
            if (r_flt_cnt != '1) n_flt_cnt = r_flt_cnt + 1'b1;
        end
    end

    // frame equals page
    assign w_phys = VA_W'({r_page, r_off});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_cnt <= '0;
            r_pg_cnt  <= '0;
            r_flt_cnt <= '0;
        end else if (i_cmd.commit) begin
            r_tlb_cnt <= n_tlb_cnt;
            r_pg_cnt  <= n_pg_cnt;
            r_flt_cnt <= n_flt_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= tlbpt_pkg::OUT_TDATA_W'(
                {n_flt_cnt, n_pg_cnt, n_tlb_cnt, w_outcome, w_phys});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== rtl/tlb_page_table_translator.sv =====
// Channel   Dir  Width  Contents (low bit first)
// s_axis    in   16     virt_addr[15:0]
// m_axis    out  120    phys_addr[15:0], outcome[17:16], tlb_hits[49:18],
//                       page_hits[81:50], page_faults[113:82], zero pad
//
// One word at a time: accept, tag compare plus present-map read, update.
// A result is registered at the update step that follows the lookup, and the
// next word is taken only after that update, so no word overlaps the last one.
// The registered present-map read sets the middle (lookup) step.
// After reset a clearing pass over all PAGE_COUNT entries runs with s_axis not ready.
// An unaccepted output word holds the update step; the input side waits.
// Top level; depends on tlbpt_pkg, tlbpt_ctrl, tlbpt_dp.
module tlb_page_table_translator #(
    parameter int TLB_DEPTH  = tlbpt_pkg::DEF_TLB_DEPTH,
    parameter int PAGE_COUNT = tlbpt_pkg::DEF_PAGE_COUNT,
    parameter int PAGE_BYTES = tlbpt_pkg::DEF_PAGE_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // virt_addr
    input  logic [tlbpt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // phys_addr, outcome, tlb_hits, page_hits, page_faults, pad
    output logic [tlbpt_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    tlbpt_pkg::t_cmd  w_cmd;
    tlbpt_pkg::t_stat w_stat;

    tlbpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    tlbpt_dp #(
        .TLB_DEPTH  (TLB_DEPTH),
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_va       (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== rtl/tlbpt_chk.sv =====
// Port-level checks for the translator, bound to the top level.
// Depends on tlbpt_pkg and tlb_page_table_translator.
module tlbpt_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [tlbpt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [tlbpt_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // held output word does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("output word changed while stalled");

    // one word in flight: no accept right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while a word is in progress");

    // counts never go down between shown words
    a_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && $past(o_m_tvalid) && $past(i_rst_n) |->
            (o_m_tdata[49:18] >= $past(o_m_tdata[49:18])) &&
            (o_m_tdata[81:50] >= $past(o_m_tdata[81:50])) &&
            (o_m_tdata[113:82] >= $past(o_m_tdata[113:82])))
        else $error("running count decreased");

    // a fault word carries a nonzero fault count
    a_fault_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[17:16] == tlbpt_pkg::OUT_FAULT) |->
            (o_m_tdata[113:82] != '0))
        else $error("fault reported with zero fault count");

endmodule

bind tlb_page_table_translator tlbpt_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
